### hdl/sarc_pkg.sv
package sarc_pkg;

  // Fixed-point format of the ramp arithmetic.
  localparam int unsigned FRAC_BITS = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_STEP_TIME = 3'd0,
    CFG_SPEED_GAIN     = 3'd1,
    CFG_SPEED_OFFSET   = 3'd2,
    CFG_CLOCK_MHZ      = 3'd3,
    CFG_CLOCK_PRESCALE = 3'd4,
    CFG_MICROSTEP_DIV  = 3'd5
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [25:0]        BASE_STEP_TIME_RST = 26'd5100667;
  localparam logic [23:0]        SPEED_GAIN_RST     = 24'd65536;
  localparam logic signed [23:0] SPEED_OFFSET_RST   = 24'sd196608;
  localparam logic [7:0]         CLOCK_MHZ_RST      = 8'd16;
  localparam logic [15:0]        CLOCK_PRESCALE_RST = 16'd8;
  localparam logic [8:0]         MICROSTEP_DIV_RST  = 9'd16;

  // Field widths.
  localparam int unsigned STEP_W   = 11;
  localparam int unsigned RELOAD_W = 16;

  // Square root unit: radicand is (n + 1) scaled by 2^(2F), root gets half the bits.
  localparam int unsigned SQ_IN_W  = STEP_W + 1 + 2 * FRAC_BITS;
  localparam int unsigned SQ_OUT_W = SQ_IN_W / 2;

  // Widths along the datapath.
  localparam int unsigned S_W   = FRAC_BITS + 1;        // sqrt difference, at most 1.0
  localparam int unsigned T_W   = 26 + S_W - FRAC_BITS; // step time
  localparam int unsigned G_W   = 24 + 9;               // gain times 300
  localparam int unsigned Q_DW  = G_W + FRAC_BITS;      // speed dividend and quotient
  localparam int unsigned RPM_W = Q_DW + 1;             // positive speed
  localparam int unsigned A_W   = 27;                   // 300000 times clock MHz
  localparam int unsigned E_W   = 25;                   // microsteps times prescale
  localparam int unsigned P_DW  = A_W + 2 * FRAC_BITS;  // period dividend and quotient

  // Scale constants of the speed and period formulas.
  localparam logic [8:0]  SPEED_NUM  = 9'd300;
  localparam logic [18:0] PERIOD_NUM = 19'd300000;

  // Full-scale reload plus one half, in fixed point.
  localparam logic [P_DW-1:0] RELOAD_LIM =
    (P_DW'(65535) << FRAC_BITS) + (P_DW'(1) << (FRAC_BITS - 1));

endpackage

### hdl/stepper_accel_reload_calc.sv
// Stepper acceleration ramp: timer reload word for one ramp step.
//
// Requests enter on the in channel (in_valid_i / in_ready_o) carrying a step
// index; results leave on the out channel (out_valid_o / out_ready_i) with the
// saturated reload word and an out-of-range flag, one result per request and
// in request order. Registers are written on the cfg channel, which is always
// ready; write them only while no request is in flight.
//
// The datapath is a pipeline of 134 register stages: two 22-stage square root
// units, a subtract and a multiply stage, a 49-stage speed divider, a speed
// offset stage, a 59-stage period divider and the output register. One request
// is taken every cycle while the receiver does not stall. A separate 59-stage
// divider runs free on the register values and supplies the period numerator.
//
// Reset clears all valid bits and loads the register defaults; the block takes
// requests right away. When the receiver stalls, the whole pipeline holds and
// in_ready_o drops; nothing is lost or repeated.
module stepper_accel_reload_calc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sarc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sarc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sarc_pkg::STEP_W-1:0]       step_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sarc_pkg::RELOAD_W-1:0]     reload_value_o,
  output logic                              out_of_range_o
);

  localparam int unsigned FB     = sarc_pkg::FRAC_BITS;
  localparam int unsigned SQ_W   = sarc_pkg::SQ_OUT_W;
  localparam int unsigned S_IDX  = SQ_W;
  localparam int unsigned T_IDX  = S_IDX + 1;
  localparam int unsigned R_IDX  = T_IDX + sarc_pkg::Q_DW + 1;
  localparam int unsigned DEPTH  = R_IDX + sarc_pkg::P_DW + 1;

  // Configuration registers.
  logic [25:0]        base_step_time_q;
  logic [23:0]        speed_gain_q;
  logic signed [23:0] speed_offset_q;
  logic [7:0]         clock_mhz_q;
  logic [15:0]        clock_prescale_q;
  logic [8:0]         microstep_div_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_step_time_q <= sarc_pkg::BASE_STEP_TIME_RST;
      speed_gain_q     <= sarc_pkg::SPEED_GAIN_RST;
      speed_offset_q   <= sarc_pkg::SPEED_OFFSET_RST;
      clock_mhz_q      <= sarc_pkg::CLOCK_MHZ_RST;
      clock_prescale_q <= sarc_pkg::CLOCK_PRESCALE_RST;
      microstep_div_q  <= sarc_pkg::MICROSTEP_DIV_RST;
    end else if (cfg_valid_i) begin
      unique case (sarc_pkg::cfg_idx_e'(cfg_index_i))
        sarc_pkg::CFG_BASE_STEP_TIME: base_step_time_q <= cfg_data_i[25:0];
        sarc_pkg::CFG_SPEED_GAIN:     speed_gain_q     <= cfg_data_i[23:0];
        sarc_pkg::CFG_SPEED_OFFSET:   speed_offset_q   <= $signed(cfg_data_i[23:0]);
        sarc_pkg::CFG_CLOCK_MHZ:      clock_mhz_q      <= cfg_data_i[7:0];
        sarc_pkg::CFG_CLOCK_PRESCALE: clock_prescale_q <= cfg_data_i[15:0];
        sarc_pkg::CFG_MICROSTEP_DIV:  microstep_div_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Products of register values, refreshed every cycle. A zero divisor acts as one.
  logic [8:0]                  mstep_eff;
  logic [15:0]                 presc_eff;
  logic [sarc_pkg::A_W-1:0]    cfg_a_q;
  logic [sarc_pkg::E_W-1:0]    cfg_e_q;
  logic [sarc_pkg::G_W-1:0]    cfg_g_q;

  assign mstep_eff = (microstep_div_q == '0) ? 9'd1 : microstep_div_q;
  assign presc_eff = (clock_prescale_q == '0) ? 16'd1 : clock_prescale_q;

  always_ff @(posedge clk_i) begin
    cfg_a_q <= sarc_pkg::A_W'(sarc_pkg::PERIOD_NUM) * sarc_pkg::A_W'(clock_mhz_q);
    cfg_e_q <= sarc_pkg::E_W'(mstep_eff) * sarc_pkg::E_W'(presc_eff);
    cfg_g_q <= sarc_pkg::G_W'(speed_gain_q) * sarc_pkg::G_W'(sarc_pkg::SPEED_NUM);
  end

  // Free-running period numerator: 300000 * MHz * 2^(2F) / (microsteps * prescale).
  logic [sarc_pkg::P_DW-1:0] pnum;

  sarc_div #(
    .DW (sarc_pkg::P_DW),
    .VW (sarc_pkg::E_W),
    .PW (1)
  ) u_pnum_div (
    .clk_i (clk_i),
    .en_i  (1'b1),
    .num_i ({cfg_a_q, {(2 * FB){1'b0}}}),
    .den_i (cfg_e_q),
    .pay_i (1'b0),
    .quo_o (pnum),
    .pay_o ()
  );

  // Pipeline advance and valid bits.
  logic             en;
  logic             accept;
  logic [DEPTH-1:0] vld_q;
  logic             out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[DEPTH-2:0], accept};
      out_valid_q <= vld_q[DEPTH-1];
    end
  end

  // Square roots of n and n + 1, scaled by 2^(2F).
  logic [sarc_pkg::STEP_W:0] n_plus1;
  logic [SQ_W-1:0]           root0;
  logic [SQ_W-1:0]           root1;

  assign n_plus1 = {1'b0, step_index_i} + 1'b1;

  sarc_isqrt u_sqrt0 (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    ({1'b0, step_index_i, {(2 * FB){1'b0}}}),
    .root_o (root0)
  );

  sarc_isqrt u_sqrt1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    ({n_plus1, {(2 * FB){1'b0}}}),
    .root_o (root1)
  );

  // Root difference, then step time t = (c0 * s) >> F.
  logic [sarc_pkg::S_W-1:0]        s_q;
  logic [25 + sarc_pkg::S_W:0]     t_prod;
  logic [sarc_pkg::T_W-1:0]        t_q;

  assign t_prod = base_step_time_q * s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q <= sarc_pkg::S_W'(root1 - root0);
      t_q <= t_prod[25 + sarc_pkg::S_W:FB];
    end
  end

  // Speed quotient (k0 * 300 << F) / t; a zero step time rides along as a flag.
  logic [sarc_pkg::Q_DW-1:0] q_quo;
  logic                      q_tz;

  sarc_div #(
    .DW (sarc_pkg::Q_DW),
    .VW (sarc_pkg::T_W),
    .PW (1)
  ) u_speed_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({cfg_g_q, {FB{1'b0}}}),
    .den_i (t_q),
    .pay_i (t_q == '0),
    .quo_o (q_quo),
    .pay_o (q_tz)
  );

  // Speed minus offset; a speed that is not positive divides by one instead.
  logic signed [sarc_pkg::RPM_W:0] rpm;
  logic                            rpm_nonpos;
  logic [sarc_pkg::RPM_W-1:0]      rpm_q;
  logic                            tz_q;
  logic                            nonpos_q;

  assign rpm = $signed({2'b00, q_quo}) -
               $signed({{(sarc_pkg::RPM_W - 23){speed_offset_q[23]}}, speed_offset_q});
  assign rpm_nonpos = rpm[sarc_pkg::RPM_W] || (rpm == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rpm_q    <= rpm_nonpos ? sarc_pkg::RPM_W'(1) : rpm[sarc_pkg::RPM_W-1:0];
      tz_q     <= q_tz;
      nonpos_q <= rpm_nonpos;
    end
  end

  // Timer count p = numerator / rpm.
  logic [sarc_pkg::P_DW-1:0] p_quo;
  logic [1:0]                p_flags;

  sarc_div #(
    .DW (sarc_pkg::P_DW),
    .VW (sarc_pkg::RPM_W),
    .PW (2)
  ) u_period_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (pnum),
    .den_i (rpm_q),
    .pay_i ({tz_q, nonpos_q}),
    .quo_o (p_quo),
    .pay_o (p_flags)
  );

  // Reload = |65535.5 - p| truncated, saturated and flagged at full scale; a speed that is not positive saturates too.
  logic [sarc_pkg::P_DW-1:0]     p_eff;
  logic [sarc_pkg::P_DW-1:0]     p_above;
  logic [sarc_pkg::P_DW-1:0]     p_below;
  logic [sarc_pkg::RELOAD_W-1:0] reload_d;
  logic                          range_d;
  logic [sarc_pkg::RELOAD_W-1:0] reload_q;
  logic                          range_q;

  assign p_eff   = p_flags[1] ? '0 : p_quo;
  assign p_above = p_eff - sarc_pkg::RELOAD_LIM;
  assign p_below = sarc_pkg::RELOAD_LIM - p_eff;

  always_comb begin
    reload_d = '1;
    range_d  = 1'b1;
    priority if (p_flags[0] && !p_flags[1]) begin
      reload_d = '1;
      range_d  = 1'b1;
    end else if (p_eff <= sarc_pkg::RELOAD_LIM) begin
      reload_d = p_below[FB + sarc_pkg::RELOAD_W - 1:FB];
      range_d  = 1'b0;
    end else if (p_above[sarc_pkg::P_DW-1:FB + sarc_pkg::RELOAD_W] != '0) begin
      reload_d = '1;
      range_d  = 1'b1;
    end else begin
      reload_d = p_above[FB + sarc_pkg::RELOAD_W - 1:FB];
      range_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      reload_q <= reload_d;
      range_q  <= range_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign reload_value_o = reload_q;
  assign out_of_range_o = range_q;

`ifndef SYNTH
  // A flagged result is always saturated.
  a_flag_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> reload_value_o == '1)
    else $error("out-of-range result not saturated");

  // The first valid bit follows the input handshake.
  a_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> vld_q[0] == $past(in_valid_i))
    else $error("entry valid bit does not match the accepted request");

  // While stalled, no valid bit moves.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(out_valid_q))
    else $error("pipeline moved during a stall");

  // The period divider never sees a zero speed.
  a_rpm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[R_IDX] |-> rpm_q != '0)
    else $error("zero divisor entering the period divider");
`endif

endmodule

### hdl/sarc_isqrt.sv
module sarc_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sarc_pkg::SQ_IN_W-1:0]  x_i,
  output logic [sarc_pkg::SQ_OUT_W-1:0] root_o
);

  localparam int unsigned W = sarc_pkg::SQ_IN_W;
  localparam int unsigned N = sarc_pkg::SQ_OUT_W;

  logic [W-1:0] rad_q  [N];
  logic [W-1:0] root_q [N];

  // One root bit per stage, starting from the most significant one.
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] Bit = W'(1) << (W - 2 - 2 * k);
    logic [W-1:0] rad_in;
    logic [W-1:0] root_in;
    logic [W-1:0] trial;
    logic         take;

    if (k == 0) begin : g_first
      assign rad_in  = x_i;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = root_in + Bit;
    assign take  = (rad_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= take ? rad_in - trial : rad_in;
        root_q[k] <= take ? (root_in >> 1) + Bit : root_in >> 1;
      end
    end
  end

  assign root_o = root_q[N-1][N-1:0];

endmodule

### hdl/sarc_div.sv
module sarc_div #(
  parameter int unsigned DW = 59,
  parameter int unsigned VW = 50,
  parameter int unsigned PW = 2
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] num_i,
  input  logic [VW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic [DW-1:0] quo_o,
  output logic [PW-1:0] pay_o
);

  logic [VW-1:0] rem_q [DW];
  logic [DW-1:0] nq_q  [DW];
  logic [VW-1:0] den_q [DW];
  logic [PW-1:0] pay_q [DW];

  // Restoring division, one quotient bit per stage. The dividend shifts out of
  // the top of nq while quotient bits shift in at the bottom.
  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [DW-1:0] nq_in;
    logic [VW-1:0] den_in;
    logic [PW-1:0] pay_in;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
      assign pay_in = pay_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
      assign pay_in = pay_q[k-1];
    end

    assign shifted = {rem_in, nq_in[DW-1]};
    assign diff    = shifted - {1'b0, den_in};
    assign take    = (shifted >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[VW-1:0] : shifted[VW-1:0];
        nq_q[k]  <= {nq_in[DW-2:0], take};
        den_q[k] <= den_in;
        pay_q[k] <= pay_in;
      end
    end
  end

  assign quo_o = nq_q[DW-1];
  assign pay_o = pay_q[DW-1];

endmodule
